FILE: rtl/ncc_pkg.sv
`default_nettype none
package ncc_pkg;

    localparam int DIM_W  = 6;
    localparam int SRCH_W = 4;
    localparam int OFF_W  = 3;
    localparam int CORR_W = 16;
    localparam int APB_DW = 32;
    localparam int APB_AW = 4;

    localparam logic [1:0] REG_REF_ROWS    = 2'd0;
    localparam logic [1:0] REG_REF_COLS    = 2'd1;
    localparam logic [1:0] REG_SEARCH_ROWS = 2'd2;
    localparam logic [1:0] REG_SEARCH_COLS = 2'd3;

    localparam int REF_DIM_RESET  = 32;
    localparam int SRCH_DIM_RESET = 8;

    localparam logic [CORR_W-1:0] Q_ONE = 16'h8000;
    localparam logic [CORR_W-1:0] Q_MAX = 16'h7FFF;
    localparam int                Q_FRAC = 32;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_MAC,
        ST_MAC_WAIT,
        ST_NSRT,
        ST_SRST,
        ST_NSTT,
        ST_STST,
        ST_NSRR,
        ST_DEN,
        ST_MAG,
        ST_BIS_STEP,
        ST_BIS_MUL,
        ST_EMIT
    } ncc_state_t;

    typedef struct packed {
        logic ref_en;
        logic tgt_en;
    } ncc_wr_t;

endpackage
`default_nettype wire

FILE: rtl/ncc_if.sv
`default_nettype none
interface ncc_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface ncc_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ncc_pkg::CORR_W-1:0]     correlation;
    logic        [ncc_pkg::OFF_W-1:0]      offset_row;
    logic        [ncc_pkg::OFF_W-1:0]      offset_col;
    logic                                  degenerate;
    logic                                  last;

    modport source (output valid, output correlation, output offset_row,
                    output offset_col, output degenerate, output last, input ready);
    modport sink   (input valid, input correlation, input offset_row,
                    input offset_col, input degenerate, input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/normalized_cross_correlation.sv
// Normalized cross-correlation of a reference tile against a search window.
// Samples arrive on the "samples" channel: first ref_rows*ref_cols reference
// samples, then (ref_rows+search_rows-1)*(ref_cols+search_cols-1) target
// samples, row-major. One sample is taken per cycle while loading.
// After the last target sample the block stops taking samples and emits
// search_rows*search_cols results on "results", row-major over offsets,
// with last set on the final one. Each offset runs the tile accumulator
// (ref_rows*ref_cols elements, one element per cycle from the two sample
// memories) and then the shared shift-add multiplier: up to seven products
// and up to 16 bisection steps. A result waits in the output register
// while the receiver stalls; the sequencer holds until the register frees
// up. Reset loads the default geometry and starts a new pair; the sample
// memories are not cleared. A configuration write restarts the loading
// of the pair, but a computation already under way runs on.
`default_nettype none
module normalized_cross_correlation #(
    parameter int MAX_REF_DIM    = 32,
    parameter int MAX_SEARCH_DIM = 8,
    parameter int SAMPLE_BITS    = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    ncc_in_if.sink                              samples,
    ncc_out_if.source                           results,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ncc_pkg::APB_AW-1:0]     paddr,
    input  wire logic [ncc_pkg::APB_DW-1:0]     pwdata,
    output logic      [ncc_pkg::APB_DW-1:0]     prdata,
    output logic                                pready
);

    localparam int SB     = SAMPLE_BITS;
    localparam int MAXN   = MAX_REF_DIM * MAX_REF_DIM;
    localparam int TD     = MAX_REF_DIM + MAX_SEARCH_DIM - 1;
    localparam int TN     = TD * TD;
    localparam int RAW    = (MAXN > 1) ? $clog2(MAXN) : 1;
    localparam int TAW    = (TN > 1) ? $clog2(TN) : 1;
    localparam int LIW    = $clog2(TN + 1);
    localparam int NB     = $clog2(MAXN + 1);
    localparam int SUMW   = SB + NB;
    localparam int PW     = 2 * SB + NB;
    localparam int NUMW   = PW + NB + 1;
    localparam int NSW    = NB + PW;
    localparam int DENW   = NB + PW + NUMW;
    localparam int AW     = DENW;
    localparam int BW     = (NUMW > 2 * ncc_pkg::CORR_W) ? NUMW : 2 * ncc_pkg::CORR_W;
    localparam int PRW    = AW + BW;
    localparam int RHSW   = 2 * NUMW + ncc_pkg::Q_FRAC;
    localparam int CMPW   = (PRW > RHSW) ? PRW : RHSW;
    localparam int DW     = ncc_pkg::DIM_W;
    localparam int SW     = ncc_pkg::SRCH_W;
    localparam int LCW    = (LIW + 1 > 2 * DW + 2) ? LIW + 1 : 2 * DW + 2;
    localparam int QW     = ncc_pkg::CORR_W;
    localparam int RR_RST = (MAX_REF_DIM < ncc_pkg::REF_DIM_RESET) ?
                            MAX_REF_DIM : ncc_pkg::REF_DIM_RESET;
    localparam int SR_RST = (MAX_SEARCH_DIM < ncc_pkg::SRCH_DIM_RESET) ?
                            MAX_SEARCH_DIM : ncc_pkg::SRCH_DIM_RESET;

    ncc_pkg::ncc_state_t state_reg, state_next;

    logic [DW-1:0]           rr_reg, rc_reg;
    logic [SW-1:0]           sr_reg, sc_reg;
    logic [LIW-1:0]          load_idx_reg;
    logic                    loading_tgt_reg;
    logic signed [SUMW-1:0]  rsum_reg;
    logic signed [PW-1:0]    rsq_reg;
    logic                    issued_reg;
    logic [ncc_pkg::OFF_W-1:0] orow_reg, ocol_reg;
    logic [TAW-1:0]          base_reg, row_base_reg;
    logic                    out_valid_reg;

    logic signed [NUMW-1:0]  p1_reg, num_reg, tv_reg;
    logic [NSW-1:0]          nsrr_reg;
    logic [DENW-1:0]         den_reg;
    logic [RHSW-1:0]         rhs_reg;
    logic [QW-1:0]           lo_reg, hi_reg, mid_reg;
    logic [2*QW-1:0]         qsq_reg;
    logic                    degen_reg;
    logic signed [QW-1:0]    out_corr_reg;
    logic [ncc_pkg::OFF_W-1:0] out_row_reg, out_col_reg;
    logic                    out_degen_reg, out_last_reg;

    logic                    cfg_wr;
    logic                    in_acc;
    logic                    slot_free;
    logic [2*DW-1:0]         n_full;
    logic [DW:0]             tr_w, tc_w;
    logic [2*DW+1:0]         tn_full;
    logic [LIW:0]            idx_inc;
    logic                    ref_done, tgt_done;
    logic [NB-1:0]           n_w;
    logic                    last_off;
    logic                    is_mul;
    logic                    mul_start, mul_done, mul_neg;
    logic [AW-1:0]           mul_a;
    logic [BW-1:0]           mul_b;
    logic signed [PRW:0]     mul_p;
    logic                    mac_start, mac_done;
    logic signed [PW-1:0]    srt_s, stt_s;
    logic signed [SUMW-1:0]  st_s;
    logic [PW-1:0]           srt_abs;
    logic [SUMW-1:0]         st_abs, rsum_abs;
    logic [NUMW-1:0]         num_abs;
    logic [QW:0]             mid_sum;
    logic [QW-1:0]           mid_w;
    logic [QW:0]             q_full;
    logic [QW-1:0]           q_w;
    logic                    lhs_le;
    logic signed [QW-1:0]    corr_w;
    logic [QW:0]             lo_neg;
    ncc_pkg::ncc_wr_t        wr;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign samples.ready = (state_reg == ncc_pkg::ST_LOAD);
    assign in_acc    = samples.valid && samples.ready;
    assign slot_free = !out_valid_reg || results.ready;

    assign n_full  = {{DW{1'b0}}, rr_reg} * {{DW{1'b0}}, rc_reg};
    assign n_w     = NB'(n_full);
    assign tr_w    = {1'b0, rr_reg} + (DW+1)'(sr_reg) - 1'b1;
    assign tc_w    = {1'b0, rc_reg} + (DW+1)'(sc_reg) - 1'b1;
    assign tn_full = {{(DW+1){1'b0}}, tr_w} * {{(DW+1){1'b0}}, tc_w};
    assign idx_inc = {1'b0, load_idx_reg} + 1'b1;
    assign ref_done = LCW'(idx_inc) >= LCW'(n_full);
    assign tgt_done = LCW'(idx_inc) >= LCW'(tn_full);
    assign last_off = ({1'b0, orow_reg} == SW'(sr_reg - 1'b1)) &&
                      ({1'b0, ocol_reg} == SW'(sc_reg - 1'b1));

    assign wr.ref_en = in_acc && !loading_tgt_reg;
    assign wr.tgt_en = in_acc && loading_tgt_reg;

    assign srt_abs  = srt_s[PW-1] ? -srt_s : srt_s;
    assign st_abs   = st_s[SUMW-1] ? -st_s : st_s;
    assign rsum_abs = rsum_reg[SUMW-1] ? -rsum_reg : rsum_reg;
    assign num_abs  = num_reg[NUMW-1] ? -num_reg : num_reg;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} + 1'b1;
    assign mid_w   = mid_sum[QW:1];
    assign q_full  = {mid_w, 1'b0} - 1'b1;
    assign q_w     = q_full[QW-1:0];
    assign lhs_le  = CMPW'(mul_p[PRW-1:0]) <= CMPW'(rhs_reg);

    assign lo_neg = -{1'b0, lo_reg};
    always_comb
    begin
        if (degen_reg)
        begin
            corr_w = '0;
        end
        else if (num_reg[NUMW-1])
        begin
            corr_w = lo_neg[QW-1:0];
        end
        else if (lo_reg == ncc_pkg::Q_ONE)
        begin
            corr_w = ncc_pkg::Q_MAX;
        end
        else
        begin
            corr_w = lo_reg;
        end
    end

    ncc_mac #(
        .SB     (SB),
        .SUMW   (SUMW),
        .PW     (PW),
        .RDEPTH (MAXN),
        .TDEPTH (TN),
        .RAW    (RAW),
        .TAW    (TAW)
    ) u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr          (wr),
        .wr_ref_addr (load_idx_reg[RAW-1:0]),
        .wr_tgt_addr (load_idx_reg[TAW-1:0]),
        .wr_data     (samples.sample),
        .start       (mac_start),
        .tgt_base    (base_reg),
        .tgt_cols    (TAW'(tc_w)),
        .ref_rows    (rr_reg),
        .ref_cols    (rc_reg),
        .done        (mac_done),
        .srt         (srt_s),
        .st          (st_s),
        .stt         (stt_s)
    );

    ncc_mul #(
        .AW (AW),
        .BW (BW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .neg   (mul_neg),
        .done  (mul_done),
        .p     (mul_p)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ncc_pkg::ST_LOAD:
            begin
                if (!cfg_wr && in_acc && loading_tgt_reg && tgt_done)
                begin
                    state_next = ncc_pkg::ST_MAC;
                end
            end
            ncc_pkg::ST_MAC:      state_next = ncc_pkg::ST_MAC_WAIT;
            ncc_pkg::ST_MAC_WAIT: if (mac_done) state_next = ncc_pkg::ST_NSRT;
            ncc_pkg::ST_NSRT:     if (mul_done) state_next = ncc_pkg::ST_SRST;
            ncc_pkg::ST_SRST:     if (mul_done) state_next = ncc_pkg::ST_NSTT;
            ncc_pkg::ST_NSTT:     if (mul_done) state_next = ncc_pkg::ST_STST;
            ncc_pkg::ST_STST:     if (mul_done) state_next = ncc_pkg::ST_NSRR;
            ncc_pkg::ST_NSRR:     if (mul_done) state_next = ncc_pkg::ST_DEN;
            ncc_pkg::ST_DEN:
            begin
                if (mul_done)
                begin
                    state_next = (mul_p == '0) ? ncc_pkg::ST_EMIT : ncc_pkg::ST_MAG;
                end
            end
            ncc_pkg::ST_MAG:      if (mul_done) state_next = ncc_pkg::ST_BIS_STEP;
            ncc_pkg::ST_BIS_STEP:
            begin
                state_next = (lo_reg >= hi_reg) ? ncc_pkg::ST_EMIT : ncc_pkg::ST_BIS_MUL;
            end
            ncc_pkg::ST_BIS_MUL:  if (mul_done) state_next = ncc_pkg::ST_BIS_STEP;
            ncc_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = last_off ? ncc_pkg::ST_LOAD : ncc_pkg::ST_MAC;
                end
            end
            default:              state_next = ncc_pkg::ST_LOAD;
        endcase
    end

    // unit control and operand selection
    always_comb
    begin
        is_mul    = 1'b0;
        mac_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        mul_neg   = 1'b0;
        unique case (state_reg)
            ncc_pkg::ST_MAC:
            begin
                mac_start = 1'b1;
            end
            ncc_pkg::ST_NSRT:
            begin
                is_mul  = 1'b1;
                mul_a   = AW'(srt_abs);
                mul_b   = BW'(n_w);
                mul_neg = srt_s[PW-1];
            end
            ncc_pkg::ST_SRST:
            begin
                is_mul  = 1'b1;
                mul_a   = AW'(rsum_abs);
                mul_b   = BW'(st_abs);
                mul_neg = rsum_reg[SUMW-1] ^ st_s[SUMW-1];
            end
            ncc_pkg::ST_NSTT:
            begin
                is_mul = 1'b1;
                mul_a  = AW'(unsigned'(stt_s));
                mul_b  = BW'(n_w);
            end
            ncc_pkg::ST_STST:
            begin
                is_mul = 1'b1;
                mul_a  = AW'(st_abs);
                mul_b  = BW'(st_abs);
            end
            ncc_pkg::ST_NSRR:
            begin
                is_mul = 1'b1;
                mul_a  = AW'(unsigned'(rsq_reg));
                mul_b  = BW'(n_w);
            end
            ncc_pkg::ST_DEN:
            begin
                is_mul = 1'b1;
                mul_a  = AW'(nsrr_reg);
                mul_b  = BW'(unsigned'(tv_reg));
            end
            ncc_pkg::ST_MAG:
            begin
                is_mul = 1'b1;
                mul_a  = AW'(num_abs);
                mul_b  = BW'(num_abs);
            end
            ncc_pkg::ST_BIS_MUL:
            begin
                is_mul = 1'b1;
                mul_a  = den_reg;
                mul_b  = BW'(qsq_reg);
            end
            default:
            begin
                is_mul = 1'b0;
            end
        endcase
    end

    assign mul_start = is_mul && !issued_reg;

    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            ncc_pkg::REG_REF_ROWS:    prdata = ncc_pkg::APB_DW'(rr_reg);
            ncc_pkg::REG_REF_COLS:    prdata = ncc_pkg::APB_DW'(rc_reg);
            ncc_pkg::REG_SEARCH_ROWS: prdata = ncc_pkg::APB_DW'(sr_reg);
            ncc_pkg::REG_SEARCH_COLS: prdata = ncc_pkg::APB_DW'(sc_reg);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ncc_pkg::ST_LOAD;
            rr_reg          <= DW'(RR_RST);
            rc_reg          <= DW'(RR_RST);
            sr_reg          <= SW'(SR_RST);
            sc_reg          <= SW'(SR_RST);
            load_idx_reg    <= '0;
            loading_tgt_reg <= 1'b0;
            rsum_reg        <= '0;
            rsq_reg         <= '0;
            issued_reg      <= 1'b0;
            orow_reg        <= '0;
            ocol_reg        <= '0;
            base_reg        <= '0;
            row_base_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (mul_start)
            begin
                issued_reg <= 1'b1;
            end
            else if (mul_done)
            begin
                issued_reg <= 1'b0;
            end

            if (results.valid && results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ncc_pkg::ST_EMIT && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end

            if (cfg_wr)
            begin
                unique case (paddr[3:2])
                    ncc_pkg::REG_REF_ROWS:
                        rr_reg <= (pwdata[DW-1:0] == '0) ? DW'(1) :
                                  (DW+1)'(pwdata[DW-1:0]) > (DW+1)'(MAX_REF_DIM) ?
                                  DW'(MAX_REF_DIM) : pwdata[DW-1:0];
                    ncc_pkg::REG_REF_COLS:
                        rc_reg <= (pwdata[DW-1:0] == '0) ? DW'(1) :
                                  (DW+1)'(pwdata[DW-1:0]) > (DW+1)'(MAX_REF_DIM) ?
                                  DW'(MAX_REF_DIM) : pwdata[DW-1:0];
                    ncc_pkg::REG_SEARCH_ROWS:
                        sr_reg <= (pwdata[SW-1:0] == '0) ? SW'(1) :
                                  (SW+1)'(pwdata[SW-1:0]) > (SW+1)'(MAX_SEARCH_DIM) ?
                                  SW'(MAX_SEARCH_DIM) : pwdata[SW-1:0];
                    ncc_pkg::REG_SEARCH_COLS:
                        sc_reg <= (pwdata[SW-1:0] == '0) ? SW'(1) :
                                  (SW+1)'(pwdata[SW-1:0]) > (SW+1)'(MAX_SEARCH_DIM) ?
                                  SW'(MAX_SEARCH_DIM) : pwdata[SW-1:0];
                    default:
                        rr_reg <= rr_reg;
                endcase
                // restart the pair
                load_idx_reg    <= '0;
                loading_tgt_reg <= 1'b0;
                rsum_reg        <= '0;
                rsq_reg         <= '0;
            end
            else if (in_acc)
            begin
                if (!loading_tgt_reg)
                begin
                    rsum_reg <= rsum_reg + SUMW'(samples.sample);
                    rsq_reg  <= rsq_reg + PW'(samples.sample * samples.sample);
                    if (ref_done)
                    begin
                        load_idx_reg    <= '0;
                        loading_tgt_reg <= 1'b1;
                    end
                    else
                    begin
                        load_idx_reg <= idx_inc[LIW-1:0];
                    end
                end
                else
                begin
                    load_idx_reg <= idx_inc[LIW-1:0];
                    if (tgt_done)
                    begin
                        orow_reg     <= '0;
                        ocol_reg     <= '0;
                        base_reg     <= '0;
                        row_base_reg <= '0;
                    end
                end
            end
            else if (state_reg == ncc_pkg::ST_EMIT && slot_free)
            begin
                if (last_off)
                begin
                    load_idx_reg    <= '0;
                    loading_tgt_reg <= 1'b0;
                    rsum_reg        <= '0;
                    rsq_reg         <= '0;
                end
                else if ({1'b0, ocol_reg} == SW'(sc_reg - 1'b1))
                begin
                    ocol_reg     <= '0;
                    orow_reg     <= orow_reg + 1'b1;
                    row_base_reg <= row_base_reg + TAW'(tc_w);
                    base_reg     <= row_base_reg + TAW'(tc_w);
                end
                else
                begin
                    ocol_reg <= ocol_reg + 1'b1;
                    base_reg <= base_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_done)
        begin
            unique case (state_reg)
                ncc_pkg::ST_NSRT: p1_reg   <= mul_p[NUMW-1:0];
                ncc_pkg::ST_SRST: num_reg  <= p1_reg - mul_p[NUMW-1:0];
                ncc_pkg::ST_NSTT: p1_reg   <= mul_p[NUMW-1:0];
                ncc_pkg::ST_STST: tv_reg   <= p1_reg - mul_p[NUMW-1:0];
                ncc_pkg::ST_NSRR: nsrr_reg <= mul_p[NSW-1:0];
                ncc_pkg::ST_DEN:
                begin
                    den_reg   <= mul_p[DENW-1:0];
                    degen_reg <= (mul_p == '0);
                end
                ncc_pkg::ST_MAG:
                begin
                    rhs_reg <= {mul_p[2*NUMW-1:0], {ncc_pkg::Q_FRAC{1'b0}}};
                    lo_reg  <= '0;
                    hi_reg  <= ncc_pkg::Q_ONE;
                end
                ncc_pkg::ST_BIS_MUL:
                begin
                    if (lhs_le)
                    begin
                        lo_reg <= mid_reg;
                    end
                    else
                    begin
                        hi_reg <= mid_reg - 1'b1;
                    end
                end
                default:
                begin
                    den_reg <= den_reg;
                end
            endcase
        end

        if (state_reg == ncc_pkg::ST_BIS_STEP)
        begin
            mid_reg <= mid_w;
            qsq_reg <= q_w * q_w;
        end

        if (state_reg == ncc_pkg::ST_EMIT && slot_free)
        begin
            out_corr_reg  <= corr_w;
            out_row_reg   <= orow_reg;
            out_col_reg   <= ocol_reg;
            out_degen_reg <= degen_reg;
            out_last_reg  <= last_off;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.correlation = out_corr_reg;
    assign results.offset_row  = out_row_reg;
    assign results.offset_col  = out_col_reg;
    assign results.degenerate  = out_degen_reg;
    assign results.last        = out_last_reg;

endmodule
`default_nettype wire

FILE: rtl/ncc_mul.sv
`default_nettype none
module ncc_mul #(
    parameter int AW = 8,
    parameter int BW = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [AW-1:0]         a,
    input  wire logic [BW-1:0]         b,
    input  wire logic                  neg,
    output logic                       done,
    output logic signed [AW+BW:0]      p
);

    logic              run_reg;
    logic              neg_reg;
    logic [BW-1:0]     b_reg;
    logic [AW+BW-1:0]  ash_reg;
    logic [AW+BW-1:0]  acc_reg;

    assign done = run_reg && (b_reg == '0);
    assign p    = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
        end
        else if (done)
        begin
            run_reg <= 1'b0;
        end
    end

    // one multiplier bit per cycle, stop as soon as no bits remain
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            b_reg   <= b;
            ash_reg <= (AW+BW)'(a);
            acc_reg <= '0;
            neg_reg <= neg;
        end
        else if (run_reg && !done)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + ash_reg;
            end
            ash_reg <= {ash_reg[AW+BW-2:0], 1'b0};
            b_reg   <= b_reg >> 1;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/ncc_mac.sv
`default_nettype none
module ncc_mac #(
    parameter int SB     = 16,
    parameter int SUMW   = 27,
    parameter int PW     = 43,
    parameter int RDEPTH = 1024,
    parameter int TDEPTH = 1521,
    parameter int RAW    = 10,
    parameter int TAW    = 11
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ncc_pkg::ncc_wr_t              wr,
    input  wire logic [RAW-1:0]                wr_ref_addr,
    input  wire logic [TAW-1:0]                wr_tgt_addr,
    input  wire logic signed [SB-1:0]          wr_data,
    input  wire logic                          start,
    input  wire logic [TAW-1:0]                tgt_base,
    input  wire logic [TAW-1:0]                tgt_cols,
    input  wire logic [ncc_pkg::DIM_W-1:0]     ref_rows,
    input  wire logic [ncc_pkg::DIM_W-1:0]     ref_cols,
    output logic                               done,
    output logic signed [PW-1:0]               srt,
    output logic signed [SUMW-1:0]             st,
    output logic signed [PW-1:0]               stt
);

    logic signed [SB-1:0] ref_mem [RDEPTH];
    logic signed [SB-1:0] tgt_mem [TDEPTH];

    logic                          issue_reg;
    logic [ncc_pkg::DIM_W-1:0]     i_reg;
    logic [ncc_pkg::DIM_W-1:0]     j_reg;
    logic [RAW-1:0]                raddr_reg;
    logic [TAW-1:0]                taddr_reg;
    logic [TAW-1:0]                trow_reg;
    logic                          v1_reg, l1_reg, v2_reg, l2_reg, done_reg;
    logic signed [SB-1:0]          r_data_reg;
    logic signed [SB-1:0]          t_data_reg;
    logic signed [2*SB-1:0]        prod_rt_reg;
    logic signed [2*SB-1:0]        prod_tt_reg;
    logic signed [SB-1:0]          t_d_reg;
    logic signed [PW-1:0]          srt_reg;
    logic signed [SUMW-1:0]        st_reg;
    logic signed [PW-1:0]          stt_reg;
    logic                          row_end;
    logic                          tile_end;

    assign row_end  = (j_reg == ref_cols - 1'b1);
    assign tile_end = row_end && (i_reg == ref_rows - 1'b1);
    assign done     = done_reg;
    assign srt      = srt_reg;
    assign st       = st_reg;
    assign stt      = stt_reg;

    always_ff @(posedge clk)
    begin
        if (wr.ref_en)
        begin
            ref_mem[wr_ref_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.tgt_en)
        begin
            tgt_mem[wr_tgt_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        r_data_reg <= ref_mem[raddr_reg];
        t_data_reg <= tgt_mem[taddr_reg];
    end

    // walk the tile: reference linearly, target slice row by row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            raddr_reg <= '0;
            taddr_reg <= '0;
            trow_reg  <= '0;
            v1_reg    <= 1'b0;
            l1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            l2_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            v1_reg   <= issue_reg && !start;
            l1_reg   <= issue_reg && !start && tile_end;
            v2_reg   <= v1_reg;
            l2_reg   <= l1_reg;
            done_reg <= v2_reg && l2_reg;
            if (start)
            begin
                issue_reg <= 1'b1;
                i_reg     <= '0;
                j_reg     <= '0;
                raddr_reg <= '0;
                taddr_reg <= tgt_base;
                trow_reg  <= tgt_base;
            end
            else if (issue_reg)
            begin
                raddr_reg <= raddr_reg + 1'b1;
                if (row_end)
                begin
                    j_reg     <= '0;
                    trow_reg  <= trow_reg + tgt_cols;
                    taddr_reg <= trow_reg + tgt_cols;
                    if (tile_end)
                    begin
                        issue_reg <= 1'b0;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                else
                begin
                    j_reg     <= j_reg + 1'b1;
                    taddr_reg <= taddr_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_rt_reg <= r_data_reg * t_data_reg;
        prod_tt_reg <= t_data_reg * t_data_reg;
        t_d_reg     <= t_data_reg;
        if (start)
        begin
            srt_reg <= '0;
            st_reg  <= '0;
            stt_reg <= '0;
        end
        else if (v2_reg)
        begin
            srt_reg <= srt_reg + PW'(prod_rt_reg);
            st_reg  <= st_reg + SUMW'(t_d_reg);
            stt_reg <= stt_reg + PW'(prod_tt_reg);
        end
    end

endmodule
`default_nettype wire
